@@ rtl/core/vrr_pkg.sv @@
`timescale 1ns / 1ps

package vrr_pkg;

	localparam int SLAB_BYTES_DEF = 4096;
	localparam int SUM_W          = 18;

	localparam logic [2:0] FN_OPEN  = 3'd0;
	localparam logic [2:0] FN_DATA  = 3'd1;
	localparam logic [2:0] FN_READ  = 3'd2;
	localparam logic [2:0] FN_POP   = 3'd3;
	localparam logic [2:0] FN_CLEAR = 3'd4;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_EMPTY  = 3'd1,
		ST_TOOBIG = 3'd2,
		ST_SEQERR = 3'd3,
		ST_OFFSET = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		RS_TAIL  = 2'd0,
		RS_TAIL1 = 2'd1,
		RS_OFFS  = 2'd2
	} rd_sel_t;

	typedef struct packed {
		logic    latch;
		logic    set_status;
		status_t status;
		logic    drop;
		logic    count_drop;
		logic    wr_lo;
		logic    wr_hi;
		logic    wr_data;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    cap_lo;
		logic    cap_hi;
		logic    cap_rval;
		logic    clear;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic [2:0] func;
		logic       rec_open;
		logic       left_zero;
		logic       too_big;
		logic       total_zero;
		logic       need_drop;
		logic       offs_bad;
		logic       out_free;
	} sts_t;

endpackage

@@ rtl/core/vrr_ctrl.sv @@
`timescale 1ns / 1ps

module vrr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  vrr_pkg::sts_t sts,
	output vrr_pkg::cmd_t cmd
);

	typedef enum logic [13:0] {
		IDLE = 14'b00000000000001,
		DISP = 14'b00000000000010,
		DCHK = 14'b00000000000100,
		DROP = 14'b00000000001000,
		LD0  = 14'b00000000010000,
		LD1  = 14'b00000000100000,
		LD2  = 14'b00000001000000,
		WRLO = 14'b00000010000000,
		WRHI = 14'b00000100000000,
		WDAT = 14'b00001000000000,
		RD   = 14'b00010000000000,
		RDW  = 14'b00100000000000,
		CLR  = 14'b01000000000000,
		FIN  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   ret_q, ret_d;

	assign in_stall = (state_q != IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		ret_d   = ret_q;
		unique case (state_q)
			IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_d   = DISP;
				end
			end
			DISP: begin
				unique case (sts.func)
					vrr_pkg::FN_OPEN: begin
						if (sts.rec_open) begin
							cmd.set_status = 1'b1;
							cmd.status     = vrr_pkg::ST_SEQERR;
							state_d        = FIN;
						end else if (sts.too_big) begin
							cmd.set_status = 1'b1;
							cmd.status     = vrr_pkg::ST_TOOBIG;
							state_d        = FIN;
						end else begin
							state_d = DCHK;
						end
					end
					vrr_pkg::FN_DATA: begin
						if (!sts.rec_open || sts.left_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = vrr_pkg::ST_SEQERR;
							state_d        = FIN;
						end else begin
							state_d = WDAT;
						end
					end
					vrr_pkg::FN_READ: begin
						if (sts.total_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = vrr_pkg::ST_EMPTY;
							state_d        = FIN;
						end else if (sts.offs_bad) begin
							cmd.set_status = 1'b1;
							cmd.status     = vrr_pkg::ST_OFFSET;
							state_d        = FIN;
						end else begin
							state_d = RD;
						end
					end
					vrr_pkg::FN_POP: begin
						if (sts.total_zero) begin
							cmd.set_status = 1'b1;
							cmd.status     = vrr_pkg::ST_EMPTY;
							state_d        = FIN;
						end else begin
							state_d = DROP;
						end
					end
					vrr_pkg::FN_CLEAR: begin
						state_d = CLR;
					end
					default: begin
						state_d = FIN;
					end
				endcase
			end
			DCHK: begin
				if (sts.need_drop) begin
					cmd.count_drop = 1'b1;
					cmd.drop       = 1'b1;
					ret_d          = 1'b1;
					state_d        = LD0;
				end else begin
					state_d = WRLO;
				end
			end
			DROP: begin
				cmd.drop = 1'b1;
				ret_d    = 1'b0;
				state_d  = LD0;
			end
			LD0: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = vrr_pkg::RS_TAIL;
				state_d    = LD1;
			end
			LD1: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = vrr_pkg::RS_TAIL1;
				cmd.cap_lo = 1'b1;
				state_d    = LD2;
			end
			LD2: begin
				cmd.cap_hi = 1'b1;
				state_d    = ret_q ? DCHK : FIN;
			end
			WRLO: begin
				cmd.wr_lo = 1'b1;
				state_d   = WRHI;
			end
			WRHI: begin
				cmd.wr_hi = 1'b1;
				ret_d     = 1'b0;
				state_d   = LD0;
			end
			WDAT: begin
				cmd.wr_data = 1'b1;
				ret_d       = 1'b0;
				state_d     = LD0;
			end
			RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = vrr_pkg::RS_OFFS;
				state_d    = RDW;
			end
			RDW: begin
				cmd.cap_rval = 1'b1;
				state_d      = FIN;
			end
			CLR: begin
				cmd.clear = 1'b1;
				state_d   = FIN;
			end
			FIN: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = IDLE;
				end
			end
			default: begin
				state_d = IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			ret_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == DISP))
		else $error("accepted transfer not dispatched");
	a_loop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == LD2 && ret_q) |=> (state_q == DCHK))
		else $error("drop loop lost");

endmodule

@@ rtl/core/vrr_dp.sv @@
`timescale 1ns / 1ps

module vrr_dp #(
	parameter int SLAB_BYTES = vrr_pkg::SLAB_BYTES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  vrr_pkg::cmd_t         cmd,
	output vrr_pkg::sts_t         sts,
	input  logic [2:0]            func,
	input  logic [15:0]           record_len,
	input  logic [7:0]            data_byte,
	input  logic [11:0]           byte_offset,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [7:0]            read_value,
	output logic [11:0]           oldest_len,
	output logic [11:0]           records_held,
	output logic [31:0]           seq_assigned,
	output logic [11:0]           dropped_count,
	output logic                  record_done
);

	localparam int AW = $clog2(SLAB_BYTES);
	localparam int SW = vrr_pkg::SUM_W;

	function automatic logic [AW-1:0] wrap_f(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = (s >= SW'(SLAB_BYTES)) ? s - SW'(SLAB_BYTES) : s;
		return r[AW-1:0];
	endfunction

	logic [7:0]    slab_q [SLAB_BYTES];
	logic [7:0]    rd_q;

	logic [AW-1:0] head_q, tail_q, wptr_q, total_q, drop_cnt_q;
	logic [AW:0]   used_q;
	logic [31:0]   seq_q;
	logic          open_q;
	logic [15:0]   left_q;
	logic [16:0]   open_total_q;
	logic [15:0]   tlen_q;

	logic [2:0]    func_q;
	logic [15:0]   rlen_q;
	logic [7:0]    dbyte_q;
	logic [11:0]   offs_q;
	vrr_pkg::status_t res_status_q;
	logic [7:0]    res_rval_q;
	logic [31:0]   res_seq_q;
	logic          res_done_q;

	logic [16:0]   need;
	logic [SW-1:0] drop_len;
	logic          commit;
	logic [16:0]   commit_len;
	logic          mem_we;
	logic [AW-1:0] waddr, raddr;
	logic [7:0]    wdata;

	assign need       = {1'b0, rlen_q} + 17'd2;
	assign drop_len   = SW'(tlen_q) + SW'(2);
	assign commit     = (cmd.wr_hi && rlen_q == 16'd0) || (cmd.wr_data && left_q == 16'd1);
	assign commit_len = cmd.wr_hi ? need : open_total_q;

	always_comb begin
		sts.func       = func_q;
		sts.rec_open   = open_q;
		sts.left_zero  = (left_q == 16'd0);
		sts.too_big    = (SW'(need) > SW'(SLAB_BYTES));
		sts.total_zero = (total_q == '0);
		sts.need_drop  = (total_q != '0) && (SW'(used_q) + SW'(need) > SW'(SLAB_BYTES));
		sts.offs_bad   = ({4'd0, offs_q} >= tlen_q);
		sts.out_free   = !out_valid || !out_stall;
	end

	always_comb begin
		mem_we = cmd.wr_lo || cmd.wr_hi || cmd.wr_data;
		if (cmd.wr_lo) begin
			waddr = head_q;
			wdata = rlen_q[7:0];
		end else if (cmd.wr_hi) begin
			waddr = wrap_f(SW'(head_q) + SW'(1));
			wdata = rlen_q[15:8];
		end else begin
			waddr = wptr_q;
			wdata = dbyte_q;
		end
		unique case (cmd.rd_sel)
			vrr_pkg::RS_TAIL:  raddr = tail_q;
			vrr_pkg::RS_TAIL1: raddr = wrap_f(SW'(tail_q) + SW'(1));
			vrr_pkg::RS_OFFS:  raddr = wrap_f(SW'(tail_q) + SW'(2) + SW'(offs_q));
			default:           raddr = tail_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slab_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rd_q <= slab_q[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q       <= func;
			rlen_q       <= record_len;
			dbyte_q      <= data_byte;
			offs_q       <= byte_offset;
			res_status_q <= vrr_pkg::ST_OK;
			res_rval_q   <= 8'd0;
			res_seq_q    <= 32'd0;
			res_done_q   <= 1'b0;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.wr_hi) begin
			res_seq_q <= seq_q;
		end
		if (commit) begin
			res_done_q <= 1'b1;
		end
		if (cmd.cap_lo) begin
			tlen_q[7:0] <= rd_q;
		end
		if (cmd.cap_hi) begin
			tlen_q[15:8] <= rd_q;
		end
		if (cmd.cap_rval) begin
			res_rval_q <= rd_q;
		end
		if (cmd.out_load) begin
			status        <= res_status_q;
			read_value    <= res_rval_q;
			oldest_len    <= (total_q != '0) ? tlen_q[11:0] : 12'd0;
			records_held  <= 12'(total_q);
			seq_assigned  <= res_seq_q;
			dropped_count <= 12'(drop_cnt_q);
			record_done   <= res_done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q       <= '0;
			tail_q       <= '0;
			wptr_q       <= '0;
			total_q      <= '0;
			drop_cnt_q   <= '0;
			used_q       <= '0;
			seq_q        <= 32'd1;
			open_q       <= 1'b0;
			left_q       <= '0;
			open_total_q <= '0;
			out_valid    <= 1'b0;
		end else begin
			if (cmd.latch) begin
				drop_cnt_q <= '0;
			end
			if (cmd.drop) begin
				tail_q  <= wrap_f(SW'(tail_q) + drop_len);
				used_q  <= (SW'(used_q) >= drop_len) ? (AW+1)'(SW'(used_q) - drop_len) : '0;
				total_q <= total_q - AW'(1);
				if (cmd.count_drop) begin
					drop_cnt_q <= drop_cnt_q + AW'(1);
				end
			end
			if (cmd.wr_hi) begin
				wptr_q       <= wrap_f(SW'(head_q) + SW'(2));
				left_q       <= rlen_q;
				open_total_q <= need;
				open_q       <= 1'b1;
			end
			if (cmd.wr_data) begin
				wptr_q <= wrap_f(SW'(wptr_q) + SW'(1));
				left_q <= left_q - 16'd1;
			end
			if (commit) begin
				head_q  <= wrap_f(SW'(head_q) + SW'(commit_len));
				used_q  <= (AW+1)'(SW'(used_q) + SW'(commit_len));
				total_q <= total_q + AW'(1);
				seq_q   <= seq_q + 32'd1;
				open_q  <= 1'b0;
				left_q  <= '0;
			end
			if (cmd.clear) begin
				head_q       <= '0;
				tail_q       <= '0;
				wptr_q       <= '0;
				total_q      <= '0;
				used_q       <= '0;
				open_q       <= 1'b0;
				left_q       <= '0;
				open_total_q <= '0;
				if (seq_q == 32'd0) begin
					seq_q <= 32'd1;
				end
			end
			if (cmd.out_load) begin
				out_valid <= 1'b1;
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/core/variable_record_ring_drop_oldest_unit.sv @@
`timescale 1ns / 1ps
// An open takes longer for each oldest record that it drops to make room.
// Throughput: one item at a time; the next input is taken once the result is
// in the output register. Each step of the drop walk rereads a 2-byte prefix
// through the single slab read port. Async active-low reset clears pointers,
// counts and the open flag and sets the sequence to 1; slab contents are not reset.
module variable_record_ring_drop_oldest_unit #(
	parameter int SLAB_BYTES = vrr_pkg::SLAB_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [15:0] record_len,
	input  logic [7:0]  data_byte,
	input  logic [11:0] byte_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [7:0]  read_value,
	output logic [11:0] oldest_len,
	output logic [11:0] records_held,
	output logic [31:0] seq_assigned,
	output logic [11:0] dropped_count,
	output logic        record_done
);

	vrr_pkg::cmd_t cmd;
	vrr_pkg::sts_t sts;

	vrr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vrr_dp #(
		.SLAB_BYTES (SLAB_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.func          (func),
		.record_len    (record_len),
		.data_byte     (data_byte),
		.byte_offset   (byte_offset),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.read_value    (read_value),
		.oldest_len    (oldest_len),
		.records_held  (records_held),
		.seq_assigned  (seq_assigned),
		.dropped_count (dropped_count),
		.record_done   (record_done)
	);

endmodule
